/* sv/rmtt_pkg.sv */
`default_nettype none
package rmtt_pkg;
    localparam int MaxTasks = 8;
    localparam int SlotW = 3;
    localparam int CountW = 4;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_TICK   = 3'd1;
    localparam logic [2:0] CMD_SELECT = 3'd2;
    localparam logic [2:0] CMD_START  = 3'd3;
    localparam logic [2:0] CMD_PAUSE  = 3'd4;
    localparam logic [2:0] CMD_CHECK  = 3'd5;

    localparam logic [3:0] EV_ADDED      = 4'd0;
    localparam logic [3:0] EV_ADD_ERR    = 4'd1;
    localparam logic [3:0] EV_RELEASED   = 4'd2;
    localparam logic [3:0] EV_NONE_REL   = 4'd3;
    localparam logic [3:0] EV_SELECTED   = 4'd4;
    localparam logic [3:0] EV_NONE_READY = 4'd5;
    localparam logic [3:0] EV_FINISHED   = 4'd6;
    localparam logic [3:0] EV_NOT_FIN    = 4'd7;
    localparam logic [3:0] EV_ACK        = 4'd8;
    localparam logic [3:0] EV_BAD_SLOT   = 4'd9;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_READY   = 2'd2;
    localparam logic [1:0] MODE_PAUSED  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;
endpackage
`default_nettype wire

/* sv/rate_monotonic_task_table.sv */
// channel | dir | beat marker          | payload
// command | in  | start & !busy        | i_command, i_slot, i_task_ident, i_task_period,
//         |     |                      | i_task_duration, i_time_now
// result  | out | o_valid (one cycle)  | o_event_res, o_event_ident, o_event_slot, o_last
//
// start, pause, check and unused codes: one decode state (ST_SCAN), then ST_DONE
// add: on error, decode then ST_DONE; else scan up to the insert position, insert, then ST_DONE
// select: scan up to the first slot that is not idle, then ST_DONE; EV_NONE_READY when all are idle
// tick: per loaded task 1 scan, 32 shared radix-2 divider steps and 1 test, then a final
// scan and ST_DONE; reset (synchronous, active low) clears control state and count
// results cannot be stalled; busy stays high until the last beat has gone out
`default_nettype none
module rate_monotonic_task_table
    import rmtt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [2:0]  i_command,
    input  wire  [2:0]  i_slot,
    input  wire  [7:0]  i_task_ident,
    input  wire  [31:0] i_task_period,
    input  wire  [31:0] i_task_duration,
    input  wire  [31:0] i_time_now,
    output logic        o_valid,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_event_ident,
    output logic [2:0]  o_event_slot,
    output logic        o_last
);
    // per-slot task state
    logic [7:0]  r_ident [MaxTasks];
    logic [31:0] r_period [MaxTasks];
    logic [31:0] r_dur [MaxTasks];
    logic [31:0] r_jstart [MaxTasks];
    logic [31:0] r_exec [MaxTasks];
    logic [15:0] r_pend [MaxTasks];
    logic [1:0]  r_mode [MaxTasks];
    logic [CountW-1:0] r_loaded;

    t_state      r_state;
    logic [2:0]  r_cmd, r_slot;
    logic [7:0]  r_tid;
    logic [31:0] r_tper, r_tdur, r_now;
    logic [CountW-1:0] r_idx;   // scan index, can reach the table depth

    // one release beat held back until it is known whether another follows
    logic        r_hold;
    logic [7:0]  r_hid;
    logic [2:0]  r_hslot;

    // shared divider: remainder only
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [5:0]  r_dcnt;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic [SlotW-1:0] idx;

    assign idx     = r_idx[SlotW-1:0];
    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_period[idx]};
    assign busy    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_loaded <= '0;
            o_valid  <= 1'b0;
            o_last   <= 1'b0;
            r_idx    <= '0;
            r_hold   <= 1'b0;
            r_dcnt   <= '0;
        end else begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd  <= i_command;
                        r_slot <= i_slot;
                        r_tid  <= i_task_ident;
                        r_tper <= i_task_period;
                        r_tdur <= i_task_duration;
                        r_now  <= i_time_now;
                        r_idx  <= '0;
                        r_hold <= 1'b0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    unique case (r_cmd)
                        CMD_ADD: begin
                            if (r_loaded >= CountW'(MaxTasks) || r_tper == '0) begin
                                o_valid <= 1'b1; o_last <= 1'b1;
                                o_event_res <= EV_ADD_ERR;
                                o_event_ident <= r_tid; o_event_slot <= '0;
                                r_state <= ST_DONE;
                            end else if (r_idx < r_loaded && r_period[idx] <= r_tper) begin
                                r_idx <= r_idx + 1'b1;
                            end else begin
                                // open the slot, shift tail one place down
                                for (int k = MaxTasks-1; k > 0; k--) begin
                                    if (k > int'(r_idx) && k <= int'(r_loaded)) begin
                                        r_ident[k]  <= r_ident[k-1];
                                        r_period[k] <= r_period[k-1];
                                        r_dur[k]    <= r_dur[k-1];
                                        r_jstart[k] <= r_jstart[k-1];
                                        r_exec[k]   <= r_exec[k-1];
                                        r_pend[k]   <= r_pend[k-1];
                                        r_mode[k]   <= r_mode[k-1];
                                    end
                                end
                                r_ident[idx]  <= r_tid;
                                r_period[idx] <= r_tper;
                                r_dur[idx]    <= r_tdur;
                                r_jstart[idx] <= '0;
                                r_exec[idx]   <= '0;
                                r_pend[idx]   <= '0;
                                r_mode[idx]   <= MODE_READY;
                                r_loaded <= r_loaded + 1'b1;
                                o_valid <= 1'b1; o_last <= 1'b1;
                                o_event_res <= EV_ADDED;
                                o_event_ident <= r_tid; o_event_slot <= idx;
                                r_state <= ST_DONE;
                            end
                        end
                        CMD_TICK: begin
                            if (r_idx < r_loaded) begin
                                r_rem  <= '0;
                                r_quo  <= r_now;
                                r_dcnt <= '0;
                                r_state <= ST_DIV;
                            end else begin
                                // flush the held release, or report that none was released, as the final beat
                                o_valid <= 1'b1; o_last <= 1'b1;
                                if (r_hold) begin
                                    o_event_res <= EV_RELEASED;
                                    o_event_ident <= r_hid; o_event_slot <= r_hslot;
                                end else begin
                                    o_event_res <= EV_NONE_REL;
                                    o_event_ident <= '0; o_event_slot <= '0;
                                end
                                r_hold <= 1'b0;
                                r_state <= ST_DONE;
                            end
                        end
                        CMD_SELECT: begin
                            if (r_idx < r_loaded && r_mode[idx] == MODE_IDLE) begin
                                r_idx <= r_idx + 1'b1;
                            end else begin
                                o_valid <= 1'b1; o_last <= 1'b1;
                                if (r_idx < r_loaded) begin
                                    o_event_res <= EV_SELECTED;
                                    o_event_ident <= r_ident[idx]; o_event_slot <= idx;
                                end else begin
                                    o_event_res <= EV_NONE_READY;
                                    o_event_ident <= '0; o_event_slot <= '0;
                                end
                                r_state <= ST_DONE;
                            end
                        end
                        CMD_START, CMD_PAUSE, CMD_CHECK: begin
                            o_valid <= 1'b1; o_last <= 1'b1;
                            o_event_slot <= r_slot;
                            if ({1'b0, r_slot} >= r_loaded) begin
                                o_event_res <= EV_BAD_SLOT;
                                o_event_ident <= '0;
                            end else begin
                                o_event_ident <= r_ident[r_slot];
                                if (r_cmd == CMD_START) begin
                                    r_jstart[r_slot] <= r_now;
                                    r_mode[r_slot] <= MODE_RUNNING;
                                    o_event_res <= EV_ACK;
                                end else if (r_cmd == CMD_PAUSE) begin
                                    r_exec[r_slot] <= r_exec[r_slot] + (r_now - r_jstart[r_slot]);
                                    r_mode[r_slot] <= MODE_PAUSED;
                                    o_event_res <= EV_ACK;
                                end else if (r_now - r_jstart[r_slot] + r_exec[r_slot]
                                             == r_dur[r_slot]) begin
                                    r_pend[r_slot] <= (r_pend[r_slot] != '0) ?
                                                      r_pend[r_slot] - 1'b1 : '0;
                                    r_mode[r_slot] <= (r_pend[r_slot] <= 16'd1) ?
                                                      MODE_IDLE : MODE_READY;
                                    r_exec[r_slot] <= '0;
                                    o_event_res <= EV_FINISHED;
                                end else begin
                                    o_event_res <= EV_NOT_FIN;
                                end
                            end
                            r_state <= ST_DONE;
                        end
                        default: r_state <= ST_DONE;
                    endcase
                end
                ST_DIV: begin
                    // one quotient bit per cycle
                    if (rem_sub[32]) r_rem <= rem_sh;
                    else r_rem <= rem_sub;
                    r_quo  <= {r_quo[30:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd31) r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (r_rem == '0) begin
                        if (r_pend[idx] != 16'hFFFF) r_pend[idx] <= r_pend[idx] + 1'b1;
                        if (r_mode[idx] == MODE_IDLE) r_mode[idx] <= MODE_READY;
                        // a newer release exists, so the held one is not the last
                        if (r_hold) begin
                            o_valid <= 1'b1;
                            o_event_res <= EV_RELEASED;
                            o_event_ident <= r_hid; o_event_slot <= r_hslot;
                        end
                        r_hold  <= 1'b1;
                        r_hid   <= r_ident[idx];
                        r_hslot <= idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    r_state <= ST_SCAN;
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded <= CountW'(MaxTasks)) else $error("task count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cmd == CMD_TICK)) else $error("divider outside tick");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("beat outside a command");
endmodule
`default_nettype wire
